// ===== hw/rtl/rpfa_pkg.sv =====
package rpfa_pkg;

    localparam int FRAME_W        = 12;
    localparam int COUNT_W        = 8;
    localparam int STATUS_W       = 3;
    localparam int ACTION_W       = 2;
    localparam int NUM_FRAMES_DEF = 4096;
    // Wide enough to hold the largest frame count the parameter allows
    localparam int LIMIT_W        = 17;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ALLOC,
        ACT_FREE,
        ACT_INCR,
        ACT_QUERY
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_NO_FRAME,
        ST_INVALID,
        ST_FULL,
        ST_SATURATED
    } status_t;

    typedef enum logic [2:0] {
        CTL_CLEAR,
        CTL_IDLE,
        CTL_READ,
        CTL_EXEC,
        CTL_WALK,
        CTL_DONE
    } ctl_state_t;

    typedef struct packed {
        logic clr;
        logic capture;
        logic rd;
        logic exec;
        logic walk;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic need_walk;
        logic walk_done;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== hw/rtl/rpfa_ctrl.sv =====
module rpfa_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  rpfa_pkg::dp_stat_t stat,
    output logic               s_ready,
    output rpfa_pkg::dp_cmd_t  cmd
);

    rpfa_pkg::ctl_state_t state_reg;
    rpfa_pkg::ctl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rpfa_pkg::CTL_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rpfa_pkg::CTL_CLEAR: begin
                if (stat.clr_last) begin
                    state_next = rpfa_pkg::CTL_IDLE;
                end
            end
            rpfa_pkg::CTL_IDLE: begin
                if (s_valid) begin
                    state_next = rpfa_pkg::CTL_READ;
                end
            end
            rpfa_pkg::CTL_READ: begin
                state_next = rpfa_pkg::CTL_EXEC;
            end
            rpfa_pkg::CTL_EXEC: begin
                state_next = stat.need_walk ? rpfa_pkg::CTL_WALK : rpfa_pkg::CTL_DONE;
            end
            rpfa_pkg::CTL_WALK: begin
                if (stat.walk_done) begin
                    state_next = rpfa_pkg::CTL_DONE;
                end
            end
            rpfa_pkg::CTL_DONE: begin
                // hold until the output register can take the result
                if (stat.out_free) begin
                    state_next = rpfa_pkg::CTL_IDLE;
                end
            end
            default: begin
                state_next = rpfa_pkg::CTL_CLEAR;
            end
        endcase
    end

    always_comb begin
        s_ready      = (state_reg == rpfa_pkg::CTL_IDLE);
        cmd.clr      = (state_reg == rpfa_pkg::CTL_CLEAR);
        cmd.capture  = (state_reg == rpfa_pkg::CTL_IDLE) && s_valid;
        cmd.rd       = (state_reg == rpfa_pkg::CTL_READ);
        cmd.exec     = (state_reg == rpfa_pkg::CTL_EXEC);
        cmd.walk     = (state_reg == rpfa_pkg::CTL_WALK);
        cmd.load_out = (state_reg == rpfa_pkg::CTL_DONE) && stat.out_free;
    end

endmodule

// ===== hw/rtl/rpfa_dp.sv =====
module rpfa_dp #(
    parameter int NUM_FRAMES = rpfa_pkg::NUM_FRAMES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  rpfa_pkg::dp_cmd_t             cmd,
    output rpfa_pkg::dp_stat_t            stat,
    input  logic [rpfa_pkg::ACTION_W-1:0] s_action,
    input  logic [rpfa_pkg::FRAME_W-1:0]  s_frame,
    input  logic                          cfg_we,
    input  logic [rpfa_pkg::FRAME_W-1:0]  cfg_wdata,
    input  logic                          m_ready,
    output logic                          m_valid,
    output logic [rpfa_pkg::STATUS_W-1:0] m_status,
    output logic [rpfa_pkg::FRAME_W-1:0]  m_granted_frame,
    output logic                          m_is_free,
    output logic [rpfa_pkg::COUNT_W-1:0]  m_count_after
);

    localparam int AW = $clog2(NUM_FRAMES);
    localparam int DW = $clog2(NUM_FRAMES + 1);
    localparam int FW = rpfa_pkg::FRAME_W;
    localparam int CW = rpfa_pkg::COUNT_W;
    localparam int LW = rpfa_pkg::LIMIT_W;

    localparam logic [LW-1:0] NUM_LIM   = LW'(NUM_FRAMES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_FRAMES - 1);
    localparam logic [DW-1:0] DEPTH_MAX = DW'(NUM_FRAMES);

    logic [FW-1:0] stk_mem [NUM_FRAMES];
    logic [CW-1:0] cnt_mem [NUM_FRAMES];

    rpfa_pkg::action_t action_reg;
    logic [FW-1:0]     frame_reg;
    logic [FW-1:0]     first_usable_reg;
    logic [DW-1:0]     depth_reg;
    logic [DW-1:0]     depth_next;
    logic [AW-1:0]     clr_idx_reg;
    logic [FW-1:0]     stk_rd_reg;
    logic [CW-1:0]     cnt_rd_reg;
    logic [DW-1:0]     walk_idx_reg;
    logic              walk_vld_reg;
    logic              found_reg;

    rpfa_pkg::status_t res_status_reg;
    logic [FW-1:0]     res_granted_reg;
    logic [CW-1:0]     res_count_reg;

    logic                          m_valid_reg;
    logic [rpfa_pkg::STATUS_W-1:0] m_status_reg;
    logic [FW-1:0]                 m_granted_reg;
    logic                          m_is_free_reg;
    logic [CW-1:0]                 m_count_reg;

    logic              frame_in_range;
    logic              grant_in_range;
    logic [AW-1:0]     frame_addr;
    logic [AW-1:0]     grant_addr;
    logic [DW-1:0]     depth_m1;
    logic              stack_empty;
    logic              stack_full;
    logic              below_first;
    logic [CW-1:0]     cnt_dec;
    logic [CW-1:0]     cnt_inc;
    logic              walk_issue;
    logic              stk_re;
    logic [AW-1:0]     stk_ra;
    logic              stk_we;
    logic              cnt_we;
    logic [AW-1:0]     cnt_wa;
    logic [CW-1:0]     cnt_wd;
    rpfa_pkg::status_t ex_status;
    logic [FW-1:0]     ex_granted;
    logic [CW-1:0]     ex_count;

    always_comb begin
        frame_in_range = {{(LW-FW){1'b0}}, frame_reg} < NUM_LIM;
        grant_in_range = {{(LW-FW){1'b0}}, stk_rd_reg} < NUM_LIM;
        frame_addr     = AW'(frame_reg);
        grant_addr     = AW'(stk_rd_reg);
        depth_m1       = depth_reg - DW'(1);
        stack_empty    = (depth_reg == '0);
        stack_full     = (depth_reg == DEPTH_MAX);
        below_first    = frame_reg < first_usable_reg;
        cnt_dec        = (cnt_rd_reg != '0) ? cnt_rd_reg - CW'(1) : '0;
        cnt_inc        = cnt_rd_reg + CW'(1);
        walk_issue     = (walk_idx_reg != depth_reg);
        stk_re         = cmd.rd || (cmd.walk && walk_issue);
        stk_ra         = cmd.walk ? walk_idx_reg[AW-1:0] : depth_m1[AW-1:0];
    end

    always_comb begin
        ex_status  = rpfa_pkg::ST_OK;
        ex_granted = '0;
        ex_count   = '0;
        cnt_we     = 1'b0;
        cnt_wa     = frame_addr;
        cnt_wd     = '0;
        stk_we     = 1'b0;
        depth_next = depth_reg;
        if (cmd.clr) begin
            cnt_we = 1'b1;
            cnt_wa = clr_idx_reg;
        end else if (cmd.exec) begin
            if (action_reg == rpfa_pkg::ACT_ALLOC) begin
                if (stack_empty) begin
                    ex_status = rpfa_pkg::ST_NO_FRAME;
                end else begin
                    depth_next = depth_m1;
                    ex_granted = stk_rd_reg;
                    ex_count   = CW'(1);
                    cnt_we     = grant_in_range;
                    cnt_wa     = grant_addr;
                    cnt_wd     = CW'(1);
                end
            end else if (!frame_in_range) begin
                ex_status = rpfa_pkg::ST_INVALID;
            end else begin
                unique case (action_reg)
                    rpfa_pkg::ACT_FREE: begin
                        if (below_first) begin
                            ex_status = rpfa_pkg::ST_INVALID;
                            ex_count  = cnt_rd_reg;
                        end else begin
                            ex_count = cnt_dec;
                            cnt_we   = 1'b1;
                            cnt_wd   = cnt_dec;
                            // last release: push the frame, or drop when full
                            if (cnt_dec == '0) begin
                                if (stack_full) begin
                                    ex_status = rpfa_pkg::ST_FULL;
                                end else begin
                                    stk_we     = 1'b1;
                                    depth_next = depth_reg + DW'(1);
                                end
                            end
                        end
                    end
                    rpfa_pkg::ACT_INCR: begin
                        if (cnt_rd_reg == rpfa_pkg::COUNT_MAX) begin
                            ex_status = rpfa_pkg::ST_SATURATED;
                            ex_count  = cnt_rd_reg;
                        end else begin
                            ex_count = cnt_inc;
                            cnt_we   = 1'b1;
                            cnt_wd   = cnt_inc;
                        end
                    end
                    rpfa_pkg::ACT_QUERY: begin
                        ex_count = cnt_rd_reg;
                    end
                    default: begin
                        ex_count = cnt_rd_reg;
                    end
                endcase
            end
        end
    end

    always_comb begin
        stat.clr_last  = (clr_idx_reg == LAST_ADDR);
        stat.need_walk = (action_reg == rpfa_pkg::ACT_QUERY) && frame_in_range && !stack_empty;
        stat.walk_done = !walk_issue && !walk_vld_reg;
        stat.out_free  = !m_valid_reg || m_ready;
    end

    // memories
    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            cnt_mem[cnt_wa] <= cnt_wd;
        end
        if (cmd.rd) begin
            cnt_rd_reg <= cnt_mem[frame_addr];
        end
        if (stk_we) begin
            stk_mem[depth_reg[AW-1:0]] <= frame_reg;
        end
        if (stk_re) begin
            stk_rd_reg <= stk_mem[stk_ra];
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            action_reg <= rpfa_pkg::action_t'(s_action);
            frame_reg  <= s_frame;
        end
        if (cmd.exec) begin
            res_status_reg  <= ex_status;
            res_granted_reg <= ex_granted;
            res_count_reg   <= ex_count;
            found_reg       <= 1'b0;
        end else if (cmd.walk && walk_vld_reg && (stk_rd_reg == frame_reg)) begin
            found_reg <= 1'b1;
        end
        if (cmd.load_out) begin
            m_status_reg  <= res_status_reg;
            m_granted_reg <= res_granted_reg;
            m_is_free_reg <= found_reg;
            m_count_reg   <= res_count_reg;
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg        <= '0;
            clr_idx_reg      <= '0;
            first_usable_reg <= '0;
            walk_idx_reg     <= '0;
            walk_vld_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            depth_reg <= depth_next;
            if (cfg_we) begin
                first_usable_reg <= cfg_wdata;
            end
            if (cmd.clr) begin
                clr_idx_reg <= clr_idx_reg + AW'(1);
            end
            if (cmd.exec) begin
                walk_idx_reg <= '0;
                walk_vld_reg <= 1'b0;
            end else if (cmd.walk) begin
                if (walk_issue) begin
                    walk_idx_reg <= walk_idx_reg + DW'(1);
                end
                walk_vld_reg <= walk_issue;
            end
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_granted_frame = m_granted_reg;
    assign m_is_free       = m_is_free_reg;
    assign m_count_after   = m_count_reg;

endmodule

// ===== hw/rtl/refcounted_page_frame_allocator.sv =====
// Channel   Handshake          Payload
// s_        s_valid/s_ready    s_action, s_frame
// m_        m_valid/m_ready    m_status, m_granted_frame, m_is_free, m_count_after
// cfg_      cfg_we             cfg_wdata (first usable frame)
//
// Allocate, free, increment: READ registers the reads of the count and stack memories,
// EXEC writes back and registers the result, DONE loads the output register.
// Query of an in-range frame on a nonempty stack also walks the stack one entry per cycle
// in WALK between EXEC and DONE. s_ready is high only in IDLE, so no request is taken
// before the last one leaves DONE. After reset the count memory is cleared one entry per
// cycle with s_ready low. A result waits in the output register while the next request is
// accepted; the result after it holds until m_ready drains the register.
module refcounted_page_frame_allocator #(
    parameter int NUM_FRAMES = rpfa_pkg::NUM_FRAMES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [rpfa_pkg::ACTION_W-1:0] s_action,
    input  logic [rpfa_pkg::FRAME_W-1:0]  s_frame,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [rpfa_pkg::STATUS_W-1:0] m_status,
    output logic [rpfa_pkg::FRAME_W-1:0]  m_granted_frame,
    output logic                          m_is_free,
    output logic [rpfa_pkg::COUNT_W-1:0]  m_count_after,
    input  logic                          cfg_we,
    input  logic [rpfa_pkg::FRAME_W-1:0]  cfg_wdata
);

    rpfa_pkg::dp_cmd_t  cmd;
    rpfa_pkg::dp_stat_t stat;

    rpfa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .stat    (stat),
        .s_ready (s_ready),
        .cmd     (cmd)
    );

    rpfa_dp #(
        .NUM_FRAMES (NUM_FRAMES)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .s_action        (s_action),
        .s_frame         (s_frame),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_status        (m_status),
        .m_granted_frame (m_granted_frame),
        .m_is_free       (m_is_free),
        .m_count_after   (m_count_after)
    );

`ifndef SYNTHESIS
    a_free_only_ok : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_is_free) |-> (m_status == rpfa_pkg::ST_OK) && (m_granted_frame == '0))
        else $error("is_free set on a non-ok or allocate result");

    a_empty_clean : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == rpfa_pkg::ST_NO_FRAME)) |->
            (m_granted_frame == '0) && (m_count_after == '0))
        else $error("failed allocate carries a frame or count");

    a_sat_max : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == rpfa_pkg::ST_SATURATED)) |->
            (m_count_after == rpfa_pkg::COUNT_MAX))
        else $error("saturated status without maximum count");

    a_full_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == rpfa_pkg::ST_FULL)) |-> (m_count_after == '0))
        else $error("dropped push with nonzero count");

    a_ready_clear : assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clr |-> !s_ready)
        else $error("request accepted during count clearing");
`endif

endmodule

// ===== test/tb_refcounted_page_frame_allocator.sv =====
`timescale 1ns / 1ps

module tb_refcounted_page_frame_allocator;

    localparam int NUM_FRAMES = rpfa_pkg::NUM_FRAMES_DEF;

    typedef struct packed {
        rpfa_pkg::status_t            status;
        logic [rpfa_pkg::FRAME_W-1:0] granted;
        logic                         is_free;
        logic [rpfa_pkg::COUNT_W-1:0] count;
    } frame_reply_t;

    // Mirror of the allocator: free list, per-frame counts and the usable floor
    class frame_ledger;
        logic [rpfa_pkg::FRAME_W-1:0] free_list [NUM_FRAMES];
        logic [rpfa_pkg::COUNT_W-1:0] counts [NUM_FRAMES];
        int unsigned                  depth;
        logic [rpfa_pkg::FRAME_W-1:0] first_usable;
        frame_reply_t                 expected_replies [$];
        logic [rpfa_pkg::FRAME_W-1:0] held_frames [$];
        int unsigned                  mismatches;

        function new();
            depth        = 0;
            first_usable = '0;
            mismatches   = 0;
            foreach (counts[i]) counts[i] = '0;
            foreach (free_list[i]) free_list[i] = '0;
        endfunction

        function void note_request(rpfa_pkg::action_t act,
                                   logic [rpfa_pkg::FRAME_W-1:0] frame);
            frame_reply_t                 r;
            logic [rpfa_pkg::FRAME_W-1:0] f;
            int unsigned                  i;
            r.status  = rpfa_pkg::ST_OK;
            r.granted = '0;
            r.is_free = 1'b0;
            r.count   = '0;
            case (act)
                rpfa_pkg::ACT_ALLOC: begin
                    if (depth == 0) begin
                        r.status = rpfa_pkg::ST_NO_FRAME;
                    end else begin
                        depth--;
                        f         = free_list[depth];
                        counts[f] = rpfa_pkg::COUNT_W'(1);
                        r.granted = f;
                        r.count   = counts[f];
                        held_frames.push_back(f);
                        if (held_frames.size() > 16) void'(held_frames.pop_front());
                    end
                end
                rpfa_pkg::ACT_FREE: begin
                    if (frame < first_usable) begin
                        r.status = rpfa_pkg::ST_INVALID;
                    end else begin
                        if (counts[frame] != 0) counts[frame]--;
                        // a zero count pushes again, even if already listed
                        if (counts[frame] == 0) begin
                            if (depth >= NUM_FRAMES) begin
                                r.status = rpfa_pkg::ST_FULL;
                            end else begin
                                free_list[depth] = frame;
                                depth++;
                            end
                        end
                    end
                    r.count = counts[frame];
                end
                rpfa_pkg::ACT_INCR: begin
                    if (counts[frame] == rpfa_pkg::COUNT_MAX) r.status = rpfa_pkg::ST_SATURATED;
                    else counts[frame]++;
                    r.count = counts[frame];
                end
                default: begin
                    for (i = 0; i < depth; i++) begin
                        if (free_list[i] == frame) r.is_free = 1'b1;
                    end
                    r.count = counts[frame];
                end
            endcase
            expected_replies.push_back(r);
        endfunction

        function void flag(string what, logic [15:0] want, logic [15:0] got);
            mismatches++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
        endfunction

        function void check_reply(frame_reply_t got);
            frame_reply_t want;
            if (expected_replies.size() == 0) begin
                mismatches++;
                $display("%0t: reply with no request pending: expected none, actual status %0d",
                         $time, got.status);
            end else begin
                want = expected_replies.pop_front();
                if (got.status !== want.status)
                    flag("status", 16'(want.status), 16'(got.status));
                if (got.granted !== want.granted)
                    flag("granted_frame", 16'(want.granted), 16'(got.granted));
                if (got.is_free !== want.is_free)
                    flag("is_free", 16'(want.is_free), 16'(got.is_free));
                if (got.count !== want.count)
                    flag("count_after", 16'(want.count), 16'(got.count));
            end
        endfunction
    endclass

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          s_valid   = 1'b0;
    logic                          s_ready;
    logic [rpfa_pkg::ACTION_W-1:0] s_action  = '0;
    logic [rpfa_pkg::FRAME_W-1:0]  s_frame   = '0;
    logic                          m_valid;
    logic                          m_ready   = 1'b0;
    logic [rpfa_pkg::STATUS_W-1:0] m_status;
    logic [rpfa_pkg::FRAME_W-1:0]  m_granted_frame;
    logic                          m_is_free;
    logic [rpfa_pkg::COUNT_W-1:0]  m_count_after;
    logic                          cfg_we    = 1'b0;
    logic [rpfa_pkg::FRAME_W-1:0]  cfg_wdata = '0;
    bit                            steady    = 1'b0;
    frame_ledger                   ledger;

    refcounted_page_frame_allocator #(
        .NUM_FRAMES(NUM_FRAMES)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_frame        (s_frame),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_granted_frame(m_granted_frame),
        .m_is_free      (m_is_free),
        .m_count_after  (m_count_after),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        frame_reply_t got;
        if (aresetn) begin
            if (s_valid && s_ready) ledger.note_request(rpfa_pkg::action_t'(s_action), s_frame);
            if (m_valid && m_ready) begin
                got.status  = rpfa_pkg::status_t'(m_status);
                got.granted = m_granted_frame;
                got.is_free = m_is_free;
                got.count   = m_count_after;
                ledger.check_reply(got);
            end
        end
    end

    // Result side: random stalls, mostly short, a few long
    initial begin : reply_sink
        int unsigned hold;
        int unsigned roll;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (hold > 0) begin
                hold--;
            end else if (steady) begin
                m_ready <= 1'b1;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 60) begin
                    m_ready <= 1'b1;
                    hold = $urandom_range(0, 4);
                end else if (roll < 95) begin
                    m_ready <= 1'b0;
                    hold = $urandom_range(0, 3);
                end else begin
                    m_ready <= 1'b0;
                    hold = $urandom_range(10, 50);
                end
            end
        end
    end

    initial begin : watchdog
        #48_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 70) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [rpfa_pkg::FRAME_W-1:0] pick_frame();
        int unsigned roll;
        int unsigned start;
        roll  = $urandom_range(0, 99);
        // stay near the usable floor so frees land on both sides of it
        start = (ledger.first_usable >= 4) ? ledger.first_usable - 4 : 0;
        if (start > NUM_FRAMES - 16) start = NUM_FRAMES - 16;
        if (roll < 40 && ledger.held_frames.size() != 0)
            return ledger.held_frames[$urandom_range(0, ledger.held_frames.size() - 1)];
        if (roll < 85) return rpfa_pkg::FRAME_W'(start + $urandom_range(0, 15));
        return rpfa_pkg::FRAME_W'($urandom);
    endfunction

    task automatic send_request(rpfa_pkg::action_t act, logic [rpfa_pkg::FRAME_W-1:0] frame);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_action <= act;
        s_frame  <= frame;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_random_request();
        int unsigned       roll;
        rpfa_pkg::action_t act;
        roll = $urandom_range(0, 99);
        if (roll < 30) act = rpfa_pkg::ACT_ALLOC;
        else if (roll < 60) act = rpfa_pkg::ACT_FREE;
        else if (roll < 80) act = rpfa_pkg::ACT_INCR;
        else act = rpfa_pkg::ACT_QUERY;
        send_request(act, pick_frame());
    endtask

    task automatic wait_for_replies();
        s_valid <= 1'b0;
        do @(posedge aclk); while (ledger.expected_replies.size() != 0);
    endtask

    task automatic write_first_usable(logic [rpfa_pkg::FRAME_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        ledger.first_usable = value;
    endtask

    initial begin : stimulus
        logic [rpfa_pkg::FRAME_W-1:0] hot;
        ledger = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        write_first_usable(rpfa_pkg::FRAME_W'(4));
        send_request(rpfa_pkg::ACT_ALLOC, '0);
        send_request(rpfa_pkg::ACT_QUERY, '0);
        send_request(rpfa_pkg::ACT_FREE, rpfa_pkg::FRAME_W'(3));
        send_request(rpfa_pkg::ACT_FREE, '1);
        send_request(rpfa_pkg::ACT_FREE, rpfa_pkg::FRAME_W'(4));
        send_request(rpfa_pkg::ACT_FREE, rpfa_pkg::FRAME_W'(4));
        send_request(rpfa_pkg::ACT_QUERY, rpfa_pkg::FRAME_W'(4));
        send_request(rpfa_pkg::ACT_QUERY, '1);
        send_request(rpfa_pkg::ACT_INCR, '0);
        send_request(rpfa_pkg::ACT_INCR, '1);
        send_request(rpfa_pkg::ACT_ALLOC, '1);
        send_request(rpfa_pkg::ACT_ALLOC, '0);
        send_request(rpfa_pkg::ACT_ALLOC, '0);
        send_request(rpfa_pkg::ACT_ALLOC, '0);
        send_request(rpfa_pkg::ACT_INCR, rpfa_pkg::FRAME_W'(4));
        send_request(rpfa_pkg::ACT_FREE, rpfa_pkg::FRAME_W'(4));
        send_request(rpfa_pkg::ACT_FREE, rpfa_pkg::FRAME_W'(4));
        send_request(rpfa_pkg::ACT_QUERY, rpfa_pkg::FRAME_W'(4));
        send_request(rpfa_pkg::ACT_FREE, '0);
        send_request(rpfa_pkg::ACT_QUERY, '1);
        send_request(rpfa_pkg::ACT_ALLOC, '0);
        wait_for_replies();

        // drive one count into saturation with no idling on either side
        steady = 1'b1;
        hot = rpfa_pkg::FRAME_W'($urandom);
        repeat (int'(rpfa_pkg::COUNT_MAX) + 2) send_request(rpfa_pkg::ACT_INCR, hot);
        send_request(rpfa_pkg::ACT_FREE, hot);
        send_request(rpfa_pkg::ACT_QUERY, hot);
        wait_for_replies();
        steady = 1'b0;

        for (int seg = 0; seg < 4; seg++) begin
            case (seg)
                0: write_first_usable('0);
                1: write_first_usable('1);
                2: write_first_usable(rpfa_pkg::FRAME_W'($urandom_range(1, 64)));
                default: write_first_usable(rpfa_pkg::FRAME_W'($urandom));
            endcase
            steady = (seg == 2);
            for (int n = 0; n < 130; n++) begin
                if (n == 65) wait_for_replies();
                send_random_request();
            end
            wait_for_replies();
        end
        steady = 1'b0;

        // a last few requests with every frame usable
        write_first_usable('0);
        send_request(rpfa_pkg::ACT_FREE, rpfa_pkg::FRAME_W'($urandom));
        send_request(rpfa_pkg::ACT_QUERY, ledger.free_list[0]);
        send_request(rpfa_pkg::ACT_QUERY, rpfa_pkg::FRAME_W'($urandom));
        send_request(rpfa_pkg::ACT_ALLOC, '0);
        send_request(rpfa_pkg::ACT_INCR, '1);
        send_request(rpfa_pkg::ACT_FREE, '1);
        send_request(rpfa_pkg::ACT_QUERY, '1);
        wait_for_replies();
        repeat (40) @(posedge aclk);

        if (ledger.mismatches == 0 && ledger.expected_replies.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
